[sv/pcm_pkg.sv]
// Package with the opcodes, status codes and field widths of the path corridor merge unit.
package pcm_pkg;

   localparam int REF_W = 32;
   localparam int LEN_W = 9;
   localparam int IDX_W = 8;
   localparam int OP_W  = 2;
   localparam int ST_W  = 3;

   typedef logic [OP_W-1:0]  opcode_type;
   typedef logic [ST_W-1:0]  status_type;
   typedef logic [REF_W-1:0] ref_type;

   localparam opcode_type OP_CLEAR   = 2'd0;
   localparam opcode_type OP_APPEND  = 2'd1;
   localparam opcode_type OP_VISITED = 2'd2;
   localparam opcode_type OP_READ    = 2'd3;

   localparam status_type ST_OK      = 3'd0;
   localparam status_type ST_FULL    = 3'd1;
   localparam status_type ST_NOMATCH = 3'd2;
   localparam status_type ST_RANGE   = 3'd3;
   localparam status_type ST_CLIP    = 3'd4;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 9'd256;

endpackage

[sv/path_corridor_merge_unit.sv]
// Top level of the path corridor merge unit: corridor memory, visited buffer and merge sequencer.
//
//  Channel    Ports                                   Handshake
//  ---------  --------------------------------------  --------------------------------------
//  request    start, busy, req_*                      transfer when start is high, busy low
//  response   rsp_valid, rsp_*                        one-cycle strobe, never held off
//  registers  psel, penable, pwrite, paddr, pwdata,   APB write in setup and access cycles,
//             prdata, pready                          pready always high
//
// Clear, append and non-final visited transfers, and a final visited transfer on an empty
// corridor, are done in the idle state; their response is registered and appears in the next
// cycle. A read keeps busy high through the RDOUT state because of the corridor memory's
// registered port, and its response is registered from that state. A merge walks the corridor
// from its end through the SRD and SCMP states for each entry examined, passes the SET1 and
// SET2 setup states, moves the tail at one entry per cycle and then drains any copy in flight,
// then writes the reversed visited part at one entry per cycle and issues the response.
// Reset is synchronous; it clears the counts and the sequencer and returns the length limit
// to 256, and the memory contents are left as they are. The response side cannot stall the unit.
module path_corridor_merge_unit #(
   parameter int CORRIDOR_DEPTH = 256,
   parameter int VISITED_DEPTH  = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  pcm_pkg::opcode_type      req_opcode,
   input  pcm_pkg::ref_type         req_poly_ref,
   input  logic [pcm_pkg::IDX_W-1:0] req_read_index,
   input  logic                     req_last_visited,
   output logic                     rsp_valid,
   output logic [pcm_pkg::LEN_W-1:0] rsp_corridor_length,
   output pcm_pkg::ref_type         rsp_read_ref,
   output pcm_pkg::status_type      rsp_status,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import pcm_pkg::*;

   localparam int CW  = $clog2(CORRIDOR_DEPTH + 1);
   localparam int AW  = $clog2(CORRIDOR_DEPTH);
   localparam int VW  = $clog2(VISITED_DEPTH + 1);
   localparam int VAW = $clog2(VISITED_DEPTH);
   localparam int LW  = (CW > LEN_W) ? CW : LEN_W;
   localparam logic [LW-1:0] DEPTH_L = LW'(CORRIDOR_DEPTH);
   localparam logic [VW-1:0] VDEPTH  = VW'(VISITED_DEPTH);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDOUT = 3'd1;
   localparam logic [2:0] S_SRD   = 3'd2;
   localparam logic [2:0] S_SCMP  = 3'd3;
   localparam logic [2:0] S_SET1  = 3'd4;
   localparam logic [2:0] S_SET2  = 3'd5;
   localparam logic [2:0] S_MOVE  = 3'd6;
   localparam logic [2:0] S_FILL  = 3'd7;

   // Corridor memory with one write port and one registered read port.
   ref_type corr_mem [CORRIDOR_DEPTH];
   ref_type rdata_ff;
   logic    mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   ref_type mem_wdata;

   // The visited buffer is small; each entry feeds its own comparator during the search.
   ref_type vis_ff [VISITED_DEPTH];
   logic    vis_we;

   logic [2:0]       state_ff, state_in;
   logic [CW-1:0]    ccount_ff, ccount_in;
   logic [VW-1:0]    vcount_ff, vcount_in;
   logic [LEN_W-1:0] maxlen_ff;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [VAW-1:0]   hitv_ff, hitv_in;
   logic [LW-1:0]    req_ff, req_in, size_ff, size_in;
   status_type       mstat_ff, mstat_in;
   logic             back_ff, back_in;
   logic [LW-1:0]    src_ff, src_in, dst_ff, dst_in, left_ff, left_in, fill_ff, fill_in;
   logic             pend_ff, pend_in;
   logic [VAW-1:0]   vidx_ff, vidx_in;
   logic             rdok_ff, rdok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] rsp_len_ff, rsp_len_in;
   ref_type          rsp_ref_ff, rsp_ref_in;
   status_type       rsp_stat_ff, rsp_stat_in;

   logic [LW-1:0] lim, ccount_x, idx_x, orig, req_raw, size_raw;
   logic          found;
   logic [VAW-1:0] hv;
   logic          emit;
   status_type    est;
   ref_type       eref;

   // The length limit in force is the smaller of the register and the memory depth.
   assign lim      = (LW'(maxlen_ff) < DEPTH_L) ? LW'(maxlen_ff) : DEPTH_L;
   assign ccount_x = LW'(ccount_ff);
   assign idx_x    = LW'(req_read_index);
   assign orig     = LW'(ptr_ff) + LW'(1);

   always_comb begin
      state_in  = state_ff;
      ccount_in = ccount_ff;
      vcount_in = vcount_ff;
      ptr_in    = ptr_ff;
      hitv_in   = hitv_ff;
      req_in    = req_ff;
      size_in   = size_ff;
      mstat_in  = mstat_ff;
      back_in   = back_ff;
      src_in    = src_ff;
      dst_in    = dst_ff;
      left_in   = left_ff;
      fill_in   = fill_ff;
      pend_in   = 1'b0;
      vidx_in   = vidx_ff;
      rdok_in   = rdok_ff;
      mem_we    = 1'b0;
      mem_waddr = ccount_ff[AW-1:0];
      mem_wdata = req_poly_ref;
      mem_raddr = ptr_ff;
      vis_we    = 1'b0;
      emit      = 1'b0;
      est       = ST_OK;
      eref      = '0;
      found     = 1'b0;
      hv        = '0;
      req_raw   = '0;
      size_raw  = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_CLEAR: begin
                     ccount_in = '0;
                     vcount_in = '0;
                     emit      = 1'b1;
                  end
                  OP_APPEND: begin
                     emit = 1'b1;
                     if (ccount_x < lim && ccount_x < DEPTH_L) begin
                        mem_we    = 1'b1;
                        ccount_in = ccount_ff + CW'(1);
                     end else begin
                        est = ST_FULL;
                     end
                  end
                  OP_VISITED: begin
                     if (vcount_ff < VDEPTH) begin
                        vis_we    = 1'b1;
                        vcount_in = vcount_ff + VW'(1);
                     end else begin
                        est = ST_FULL;
                     end
                     if (!req_last_visited) begin
                        emit = 1'b1;
                     end else if (ccount_ff == '0) begin
                        emit      = 1'b1;
                        est       = ST_NOMATCH;
                        vcount_in = '0;
                     end else begin
                        ptr_in   = AW'(ccount_x - LW'(1));
                        state_in = S_SRD;
                     end
                  end
                  default: begin
                     mem_raddr = idx_x[AW-1:0];
                     rdok_in   = (idx_x < ccount_x) && (idx_x < DEPTH_L);
                     state_in  = S_RDOUT;
                  end
               endcase
            end
         end
         S_RDOUT: begin
            emit     = 1'b1;
            eref     = rdok_ff ? rdata_ff : '0;
            est      = rdok_ff ? ST_OK : ST_RANGE;
            state_in = S_IDLE;
         end
         S_SRD: begin
            state_in = S_SCMP;
         end
         S_SCMP: begin
            // Lowest buffered index that matches this corridor entry.
            for (int j = VISITED_DEPTH - 1; j >= 0; j--) begin
               if (VW'(j) < vcount_ff && rdata_ff == vis_ff[j]) begin
                  found = 1'b1;
                  hv    = VAW'(j);
               end
            end
            if (found) begin
               hitv_in  = hv;
               state_in = S_SET1;
            end else if (ptr_ff == '0) begin
               emit      = 1'b1;
               est       = ST_NOMATCH;
               vcount_in = '0;
               state_in  = S_IDLE;
            end else begin
               ptr_in   = ptr_ff - AW'(1);
               state_in = S_SRD;
            end
         end
         S_SET1: begin
            req_raw  = LW'(vcount_ff) - LW'(hitv_ff);
            size_raw = ccount_x - orig;
            mstat_in = ST_OK;
            req_in   = req_raw;
            size_in  = size_raw;
            if (req_raw > lim) begin
               req_in   = lim;
               size_in  = '0;
               mstat_in = ST_CLIP;
            end else if (req_raw + size_raw > lim) begin
               size_in  = lim - req_raw;
               mstat_in = ST_CLIP;
            end
            state_in = S_SET2;
         end
         S_SET2: begin
            // A tail that moves toward the end is copied from its last entry down.
            back_in = req_ff > orig;
            if (req_ff > orig) begin
               src_in = orig + size_ff - LW'(1);
               dst_in = req_ff + size_ff - LW'(1);
            end else begin
               src_in = orig;
               dst_in = req_ff;
            end
            left_in  = size_ff;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            if (left_ff != '0) begin
               mem_raddr = src_ff[AW-1:0];
               src_in    = back_ff ? src_ff - LW'(1) : src_ff + LW'(1);
               left_in   = left_ff - LW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff[AW-1:0];
               mem_wdata = rdata_ff;
               dst_in    = back_ff ? dst_ff - LW'(1) : dst_ff + LW'(1);
            end
            if (left_ff == '0 && !pend_ff) begin
               fill_in  = '0;
               vidx_in  = VAW'(vcount_ff - VW'(1));
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (fill_ff < req_ff) begin
               mem_we    = 1'b1;
               mem_waddr = fill_ff[AW-1:0];
               mem_wdata = vis_ff[vidx_ff];
               fill_in   = fill_ff + LW'(1);
               vidx_in   = vidx_ff - VAW'(1);
            end else begin
               ccount_in = CW'(req_ff + size_ff);
               vcount_in = '0;
               emit      = 1'b1;
               est       = mstat_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit;
      rsp_len_in   = LEN_W'(LW'(ccount_in));
      rsp_ref_in   = eref;
      rsp_stat_in  = est;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         corr_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= corr_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_ff[vcount_ff[VAW-1:0]] <= req_poly_ref;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ccount_ff    <= '0;
         vcount_ff    <= '0;
         maxlen_ff    <= MAX_LEN_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ccount_ff    <= ccount_in;
         vcount_ff    <= vcount_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (psel && penable && pwrite && paddr == 3'd0) begin
            maxlen_ff <= pwdata[LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      hitv_ff     <= hitv_in;
      req_ff      <= req_in;
      size_ff     <= size_in;
      mstat_ff    <= mstat_in;
      back_ff     <= back_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      left_ff     <= left_in;
      fill_ff     <= fill_in;
      vidx_ff     <= vidx_in;
      rdok_ff     <= rdok_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_ref_ff  <= rsp_ref_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corridor_length = rsp_len_ff;
   assign rsp_read_ref        = rsp_ref_ff;
   assign rsp_status          = rsp_stat_ff;
   assign prdata              = (paddr == 3'd0) ? 32'(maxlen_ff) : 32'd0;
   assign pready              = 1'b1;

`ifndef SYNTHESIS
   // The corridor never grows past the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      LW'(ccount_ff) <= DEPTH_L)
      else $error("corridor count beyond depth");

   // During the tail move a write never lands on the entry being read.
   a_move_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE && pend_ff && left_ff != '0) |-> (dst_ff != src_ff))
      else $error("tail move overlaps read and write");

   // No copy is left in flight once the sequencer is idle.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_ff)
      else $error("pending copy while idle");

   // A read transfer is answered with a response strobe once the sequencer has passed RDOUT.
   a_read_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_READ) |=> ##1 rsp_valid)
      else $error("read response missing");
`endif

endmodule
